FILE: hdl/irpwfd_pkg.sv
// irpwfd_pkg: shared types, constants and register codes for the ir frame decoder
`default_nettype none
package irpwfd_pkg;

    // fixed field widths
    localparam int TS_W   = 16;
    localparam int CODE_W = 7;
    localparam int SLOT_W = 3;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    // frame length default, abort limit and time base wrap
    localparam int FRAME_BITS_DEF = 7;
    localparam logic [TS_W-1:0] ABORT_TICKS  = 16'd300;
    localparam logic [TS_W:0]   TIME_MODULUS = 17'd65535;

    // register reset values
    localparam logic [TS_W-1:0]   LEADER_MIN_RST = 16'd370;
    localparam logic [TS_W-1:0]   LEADER_MAX_RST = 16'd550;
    localparam logic [TS_W-1:0]   ONE_MIN_RST    = 16'd100;
    localparam logic [TS_W-1:0]   ONE_MAX_RST    = 16'd210;
    localparam logic [CODE_W-1:0] CODE_RST       = 7'd0;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_LEADER_MIN     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_LEADER_MAX     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ONE_MIN        = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ONE_MAX        = 3'd3;
    localparam logic [IDX_W-1:0] CFG_CODE_LEFT      = 3'd4;
    localparam logic [IDX_W-1:0] CFG_CODE_MID_LEFT  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_CODE_RIGHT     = 3'd6;
    localparam logic [IDX_W-1:0] CFG_CODE_MID_RIGHT = 3'd7;

    // match slot codes
    localparam logic [SLOT_W-1:0] SLOT_NONE      = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_LEFT      = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_MID_LEFT  = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_RIGHT     = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_MID_RIGHT = 3'd4;

    typedef struct packed {
        logic            pin_level;
        logic [TS_W-1:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic              frame_done;
        logic [CODE_W-1:0] frame_code;
        logic [SLOT_W-1:0] match_slot;
        logic              leader_found;
        logic              aborted;
    } t_out_item;

    typedef struct packed {
        logic [TS_W-1:0]   leader_min;
        logic [TS_W-1:0]   leader_max;
        logic [TS_W-1:0]   one_min;
        logic [TS_W-1:0]   one_max;
        logic [CODE_W-1:0] code_left;
        logic [CODE_W-1:0] code_mid_left;
        logic [CODE_W-1:0] code_right;
        logic [CODE_W-1:0] code_mid_right;
    } t_cfg;

endpackage
`default_nettype wire

FILE: hdl/irpwfd_cfg_regs.sv
// irpwfd_cfg_regs: configuration register file with plain write port
`default_nettype none
module irpwfd_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [irpwfd_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [irpwfd_pkg::CFG_W-1:0]  i_cfg_data,
    output irpwfd_pkg::t_cfg                   o_cfg
);
    import irpwfd_pkg::*;

    t_cfg r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leader_min     <= LEADER_MIN_RST;
            r_cfg.leader_max     <= LEADER_MAX_RST;
            r_cfg.one_min        <= ONE_MIN_RST;
            r_cfg.one_max        <= ONE_MAX_RST;
            r_cfg.code_left      <= CODE_RST;
            r_cfg.code_mid_left  <= CODE_RST;
            r_cfg.code_right     <= CODE_RST;
            r_cfg.code_mid_right <= CODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEADER_MIN:     r_cfg.leader_min     <= i_cfg_data[TS_W-1:0];
                CFG_LEADER_MAX:     r_cfg.leader_max     <= i_cfg_data[TS_W-1:0];
                CFG_ONE_MIN:        r_cfg.one_min        <= i_cfg_data[TS_W-1:0];
                CFG_ONE_MAX:        r_cfg.one_max        <= i_cfg_data[TS_W-1:0];
                CFG_CODE_LEFT:      r_cfg.code_left      <= i_cfg_data[CODE_W-1:0];
                CFG_CODE_MID_LEFT:  r_cfg.code_mid_left  <= i_cfg_data[CODE_W-1:0];
                CFG_CODE_RIGHT:     r_cfg.code_right     <= i_cfg_data[CODE_W-1:0];
                CFG_CODE_MID_RIGHT: r_cfg.code_mid_right <= i_cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

FILE: hdl/irpwfd_slot_match.sv
// irpwfd_slot_match: priority match of a received code against the four slots
`default_nettype none
module irpwfd_slot_match #(
    parameter int W = 7
) (
    input  wire logic [W-1:0]                  i_data,
    input  wire irpwfd_pkg::t_cfg              i_cfg,
    output logic [irpwfd_pkg::SLOT_W-1:0]      o_slot
);
    import irpwfd_pkg::*;

    // first hit in order left, mid-left, right, mid-right
    always_comb begin
        if (i_data == W'(i_cfg.code_left)) begin
            o_slot = SLOT_LEFT;
        end else if (i_data == W'(i_cfg.code_mid_left)) begin
            o_slot = SLOT_MID_LEFT;
        end else if (i_data == W'(i_cfg.code_right)) begin
            o_slot = SLOT_RIGHT;
        end else if (i_data == W'(i_cfg.code_mid_right)) begin
            o_slot = SLOT_MID_RIGHT;
        end else begin
            o_slot = SLOT_NONE;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/irpwfd_step.sv
// irpwfd_step: decoder state and the per-edge pulse timing and bit decode
`default_nettype none
module irpwfd_step #(
    parameter int FRAME_BITS = irpwfd_pkg::FRAME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire irpwfd_pkg::t_in_item i_item,
    input  wire irpwfd_pkg::t_cfg     i_cfg,
    output irpwfd_pkg::t_out_item     o_result
);
    import irpwfd_pkg::*;

    localparam int CW   = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
    localparam int CMPW = (FRAME_BITS > CODE_W) ? FRAME_BITS : CODE_W;
    localparam logic [CW-1:0] LAST_BIT = CW'(FRAME_BITS - 1);

    logic                  r_rise_seen, n_rise_seen;
    logic                  r_in_frame,  n_in_frame;
    logic [CW-1:0]         r_bit_count, n_bit_count;
    logic [FRAME_BITS-1:0] r_shift,     n_shift;
    logic [TS_W-1:0]       r_rise_time, n_rise_time;

    logic [TS_W:0]         wrap_sum;
    logic [TS_W-1:0]       width;
    logic                  in_leader_win;
    logic                  in_one_win;
    logic                  too_long;
    logic [FRAME_BITS-1:0] shift_bit;
    logic [CMPW-1:0]       code_ext;
    logic [SLOT_W-1:0]     slot;
    t_out_item             res;

    // pulse width with time base wrap
    assign wrap_sum = {1'b0, i_item.timestamp} + TIME_MODULUS - {1'b0, r_rise_time};
    assign width    = (i_item.timestamp >= r_rise_time) ?
                      (i_item.timestamp - r_rise_time) : wrap_sum[TS_W-1:0];

    // window tests
    assign in_leader_win = (width >= i_cfg.leader_min) && (width < i_cfg.leader_max);
    assign in_one_win    = (width >= i_cfg.one_min) && (width < i_cfg.one_max);
    assign too_long      = !in_one_win && (width >= ABORT_TICKS);

    assign shift_bit = r_shift | FRAME_BITS'(in_one_win);
    assign code_ext  = CMPW'(shift_bit);

    irpwfd_slot_match #(.W(CMPW)) u_slot_match (
        .i_data (code_ext),
        .i_cfg  (i_cfg),
        .o_slot (slot)
    );

    // next state and result for one edge event
    always_comb begin
        n_rise_seen = r_rise_seen;
        n_in_frame  = r_in_frame;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_rise_time = r_rise_time;
        res         = '0;
        if (!r_rise_seen) begin
            if (i_item.pin_level) begin
                n_rise_time = i_item.timestamp;
                n_rise_seen = 1'b1;
            end
        end else if (!i_item.pin_level) begin
            n_rise_seen = 1'b0;
            if (!r_in_frame) begin
                if (in_leader_win) begin
                    n_in_frame       = 1'b1;
                    n_shift          = '0;
                    n_bit_count      = '0;
                    res.leader_found = 1'b1;
                end
            end else if (too_long) begin
                n_in_frame  = 1'b0;
                n_bit_count = '0;
                n_shift     = '0;
                res.aborted = 1'b1;
            end else if (r_bit_count == LAST_BIT) begin
                n_shift        = shift_bit;
                n_in_frame     = 1'b0;
                n_bit_count    = '0;
                res.frame_done = 1'b1;
                res.frame_code = code_ext[CODE_W-1:0];
                res.match_slot = slot;
            end else begin
                n_bit_count = r_bit_count + 1'b1;
                n_shift     = shift_bit << 1;
            end
        end
    end

    // state update on each processed event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_seen <= 1'b0;
            r_in_frame  <= 1'b0;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_rise_time <= '0;
        end else if (i_fire) begin
            r_rise_seen <= n_rise_seen;
            r_in_frame  <= n_in_frame;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_rise_time <= n_rise_time;
        end
    end

    assign o_result = res;

endmodule
`default_nettype wire

FILE: hdl/ir_pulse_width_frame_decoder_core.sv
// ir_pulse_width_frame_decoder_core: top level of the ir pulse width frame decoder
//
//   channel   direction  handshake                   payload
//   in        input      i_in_valid / o_in_ready     i_in_data  (t_in_item)
//   out       output     o_out_valid / i_out_ready   o_out_data (t_out_item)
//   cfg       input      i_cfg_we                    i_cfg_index, i_cfg_data
//
// one edge event per cycle while the output drains; each event gives exactly
// one result, via the input register, then decode into the result register
// the decode is one compare-and-update step on the pulse state registers
// synchronous active-low reset clears the pipeline valids, decoder state and
// config registers to their defaults
// a stalled output holds the result; the input register keeps taking events
// while it is empty or the result register can drain
`default_nettype none
module ir_pulse_width_frame_decoder_core #(
    parameter int FRAME_BITS = irpwfd_pkg::FRAME_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire irpwfd_pkg::t_in_item          i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output irpwfd_pkg::t_out_item              o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [irpwfd_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [irpwfd_pkg::CFG_W-1:0]  i_cfg_data
);
    import irpwfd_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld;
    t_out_item r_out_item;
    logic      advance;
    logic      fire;
    t_cfg      cfg;
    t_out_item result;

    irpwfd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // pipeline flow control
    assign advance    = !r_out_vld || i_out_ready;
    assign fire       = r_in_vld && advance;
    assign o_in_ready = !r_in_vld || advance;

    irpwfd_step #(.FRAME_BITS(FRAME_BITS)) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_item;

endmodule
`default_nettype wire

FILE: hdl/irpwfd_checker.sv
// irpwfd_checker: port-level assertions for the decoder core and their bind
`default_nettype none
module irpwfd_checker (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  o_in_ready,
    input  wire logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    input  wire irpwfd_pkg::t_out_item o_out_data
);
    import irpwfd_pkg::*;

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result transfer keeps valid and payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a finished frame is neither a leader nor an abort
    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_done |->
            !o_out_data.leader_found && !o_out_data.aborted)
        else $error("frame done with leader or abort");

    // code and slot are zero without a finished frame
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.frame_done |->
            o_out_data.frame_code == '0 && o_out_data.match_slot == SLOT_NONE)
        else $error("code or slot set without frame done");

    // an input transfer while the result drains gives a result after the input and result registers
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (!o_out_valid || i_out_ready) |=> ##1 o_out_valid)
        else $error("accepted event produced no result");

endmodule

bind ir_pulse_width_frame_decoder_core irpwfd_checker u_irpwfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire

FILE: verif/testbench.sv
// testbench: self-checking test of the ir pulse width frame decoder core
`timescale 1ns / 100ps
module testbench;
    import irpwfd_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 6;
    localparam int TS_TOP        = 65534;

    typedef enum logic [1:0] {ROW_QUIET, ROW_LEADER, ROW_ABORT, ROW_PREDICT} t_row_kind;

    typedef struct {
        logic            level;
        logic [TS_W-1:0] ts;
        t_row_kind       kind;
    } t_script_row;

    // block ports
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in_item         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_item        o_out_data;
    logic             i_cfg_we    = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    // decoder prediction state and register copy
    t_cfg             cfg_now;
    bit               rise_pending;
    bit               frame_open;
    bit [2:0]         bits_taken;
    bit [CODE_W-1:0]  shift_reg;
    bit [TS_W-1:0]    rise_stamp;

    // scoreboard and bookkeeping
    t_out_item        results_due[$];
    t_script_row      script[$];
    int               fail_count    = 0;
    int               cycle_count   = 0;
    int               edges_sent    = 0;
    int               frames_out    = 0;
    int               slot_hits     = 0;
    int               leaders_out   = 0;
    int               aborts_out    = 0;
    int               settings_used = 0;
    int               ready_hold    = 0;
    int unsigned      now_ts        = 0;
    bit               in_gaps_on    = 1'b0;
    bit               out_stalls_on = 1'b0;

    ir_pulse_width_frame_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // first configured code that equals the frame wins
    function automatic logic [SLOT_W-1:0] slot_for(logic [CODE_W-1:0] code);
        if (code == cfg_now.code_left)      return SLOT_LEFT;
        if (code == cfg_now.code_mid_left)  return SLOT_MID_LEFT;
        if (code == cfg_now.code_right)     return SLOT_RIGHT;
        if (code == cfg_now.code_mid_right) return SLOT_MID_RIGHT;
        return SLOT_NONE;
    endfunction

    // one edge event through the pulse timer and frame state
    function automatic t_out_item decode_edge(t_in_item ev);
        t_out_item       r;
        logic [TS_W:0]   span;
        logic [TS_W-1:0] width;
        bit              is_one;
        r = '0;
        if (!rise_pending) begin
            if (ev.pin_level) begin
                rise_stamp   = ev.timestamp;
                rise_pending = 1'b1;
            end
        end else if (!ev.pin_level) begin
            // pulse width across the time base wrap
            if (ev.timestamp >= rise_stamp)
                span = {1'b0, ev.timestamp} - {1'b0, rise_stamp};
            else
                span = TIME_MODULUS + {1'b0, ev.timestamp} - {1'b0, rise_stamp};
            width        = span[TS_W-1:0];
            rise_pending = 1'b0;
            if (!frame_open) begin
                if (width >= cfg_now.leader_min && width < cfg_now.leader_max) begin
                    frame_open     = 1'b1;
                    shift_reg      = '0;
                    bits_taken     = '0;
                    r.leader_found = 1'b1;
                end
            end else begin
                // one window has priority over the abort limit
                is_one = (width >= cfg_now.one_min && width < cfg_now.one_max);
                if (!is_one && width >= ABORT_TICKS) begin
                    frame_open = 1'b0;
                    bits_taken = '0;
                    shift_reg  = '0;
                    r.aborted  = 1'b1;
                end else begin
                    if (is_one) shift_reg[0] = 1'b1;
                    if (bits_taken >= FRAME_BITS_DEF - 1) begin
                        r.frame_done = 1'b1;
                        r.frame_code = shift_reg;
                        r.match_slot = slot_for(shift_reg);
                        frame_open   = 1'b0;
                        bits_taken   = '0;
                    end else begin
                        bits_taken++;
                        shift_reg = shift_reg << 1;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic t_out_item fixed_result(t_row_kind kind);
        t_out_item r;
        r = '0;
        if (kind == ROW_LEADER) r.leader_found = 1'b1;
        if (kind == ROW_ABORT)  r.aborted = 1'b1;
        return r;
    endfunction

    function automatic t_cfg make_cfg(int unsigned lmin, int unsigned lmax, int unsigned omin,
                                      int unsigned omax, t_cfg codes);
        t_cfg c;
        c            = codes;
        c.leader_min = lmin[TS_W-1:0];
        c.leader_max = lmax[TS_W-1:0];
        c.one_min    = omin[TS_W-1:0];
        c.one_max    = omax[TS_W-1:0];
        return c;
    endfunction

    // random windows, codes sometimes copied from a neighbour so that several slots can match
    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.leader_min = TS_W'($urandom_range(0, 600));
        c.leader_max = c.leader_min + TS_W'($urandom_range(0, 400));
        c.one_min    = TS_W'($urandom_range(0, 250));
        c.one_max    = c.one_min + TS_W'($urandom_range(0, 250));
        if ($urandom_range(0, 3) == 0) c.one_max = TS_W'($urandom_range(0, 65535));
        c.code_left      = CODE_W'($urandom_range(0, 127));
        c.code_mid_left  = $urandom_range(0, 1) ? c.code_left
                                                : CODE_W'($urandom_range(0, 127));
        c.code_right     = $urandom_range(0, 1) ? c.code_mid_left
                                                : CODE_W'($urandom_range(0, 127));
        c.code_mid_right = CODE_W'($urandom_range(0, 127));
        return c;
    endfunction

    function automatic int unsigned pick_in_window(int unsigned lo, int unsigned hi);
        int unsigned r;
        if (lo >= hi) return $urandom_range(0, TS_TOP);
        r = $urandom_range(0, 9);
        if (r == 0) return lo;
        if (r == 1) return hi - 1;
        return $urandom_range(lo, hi - 1);
    endfunction

    // a pulse that shifts in a zero without aborting, where one exists
    function automatic int unsigned zero_width();
        int unsigned w;
        repeat (8) begin
            case ($urandom_range(0, 4))
                0: w = cfg_now.one_max;
                1: w = ABORT_TICKS - 1;
                2: w = (cfg_now.one_min > 0) ? cfg_now.one_min - 1 : 0;
                default: w = $urandom_range(0, ABORT_TICKS - 1);
            endcase
            if (w < ABORT_TICKS && !(w >= cfg_now.one_min && w < cfg_now.one_max)) return w;
        end
        return $urandom_range(0, TS_TOP);
    endfunction

    function automatic int unsigned abort_width();
        if ($urandom_range(0, 3) == 0) return ABORT_TICKS;
        return $urandom_range(ABORT_TICKS, TS_TOP);
    endfunction

    // output ready with random stalls
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold  <= ready_hold - 1;
            i_out_ready <= 1'b0;
        end else if (out_stalls_on && $urandom_range(0, 99) < 25) begin
            ready_hold  <= pick_gap();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_watch
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                $error("result transfer with nothing expected: %h", o_out_data);
                fail_count++;
            end else begin
                want = results_due.pop_front();
                check_field("frame_done", want.frame_done, o_out_data.frame_done);
                check_field("frame_code", want.frame_code, o_out_data.frame_code);
                check_field("match_slot", want.match_slot, o_out_data.match_slot);
                check_field("leader_found", want.leader_found, o_out_data.leader_found);
                check_field("aborted", want.aborted, o_out_data.aborted);
                if (want.frame_done) frames_out++;
                if (want.frame_done && want.match_slot != SLOT_NONE) slot_hits++;
                if (want.leader_found) leaders_out++;
                if (want.aborted) aborts_out++;
            end
        end
    end

    // one edge transfer; valid stays up when the next edge follows at once
    task automatic push_edge(input logic level, input logic [TS_W-1:0] ts,
                             input bit use_fixed = 1'b0, input t_out_item fixed_out = '0);
        int        gap;
        t_in_item  ev;
        t_out_item predicted;
        ev.pin_level = level;
        ev.timestamp = ts;
        gap = (in_gaps_on && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = decode_edge(ev);
        results_due.push_back(use_fixed ? fixed_out : predicted);
        edges_sent++;
    endtask

    // sender holds off until every result is back and the pipe is quiet
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_LEADER_MIN:     cfg_now.leader_min     = value;
            CFG_LEADER_MAX:     cfg_now.leader_max     = value;
            CFG_ONE_MIN:        cfg_now.one_min        = value;
            CFG_ONE_MAX:        cfg_now.one_max        = value;
            CFG_CODE_LEFT:      cfg_now.code_left      = value[CODE_W-1:0];
            CFG_CODE_MID_LEFT:  cfg_now.code_mid_left  = value[CODE_W-1:0];
            CFG_CODE_RIGHT:     cfg_now.code_right     = value[CODE_W-1:0];
            CFG_CODE_MID_RIGHT: cfg_now.code_mid_right = value[CODE_W-1:0];
            default: ;
        endcase
    endtask

    // code writes carry random upper bits, which the block must drop
    function automatic logic [CFG_W-1:0] code_word(logic [CODE_W-1:0] code);
        logic [CFG_W-CODE_W-1:0] junk;
        junk = $urandom_range(0, 1) ? '0 : (CFG_W-CODE_W)'($urandom);
        return {junk, code};
    endfunction

    task automatic load_settings(input t_cfg c);
        drain_results();
        write_reg(CFG_LEADER_MIN, c.leader_min);
        write_reg(CFG_LEADER_MAX, c.leader_max);
        write_reg(CFG_ONE_MIN, c.one_min);
        write_reg(CFG_ONE_MAX, c.one_max);
        write_reg(CFG_CODE_LEFT, code_word(c.code_left));
        write_reg(CFG_CODE_MID_LEFT, code_word(c.code_mid_left));
        write_reg(CFG_CODE_RIGHT, code_word(c.code_right));
        write_reg(CFG_CODE_MID_RIGHT, code_word(c.code_mid_right));
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // rise after a short low time, fall after the given width
    task automatic send_pulse(input int unsigned width);
        int unsigned rise;
        rise = (now_ts + $urandom_range(1, 300)) % 65535;
        if ($urandom_range(0, 63) == 0) rise = 65535;
        push_edge(1'b1, rise[TS_W-1:0]);
        now_ts = (rise + width) % 65535;
        push_edge(1'b0, now_ts[TS_W-1:0]);
    endtask

    task automatic send_noise(input int count);
        repeat (count) push_edge(1'($urandom_range(0, 1)), TS_W'($urandom_range(0, 65535)));
    endtask

    // leader and seven bits carrying a code, now and then broken up
    task automatic send_frame();
        logic [CODE_W-1:0] code;
        int unsigned       w;
        case ($urandom_range(0, 5))
            0: code = cfg_now.code_left;
            1: code = cfg_now.code_mid_left;
            2: code = cfg_now.code_right;
            3: code = cfg_now.code_mid_right;
            default: code = CODE_W'($urandom_range(0, 127));
        endcase
        send_pulse(pick_in_window(cfg_now.leader_min, cfg_now.leader_max));
        for (int k = CODE_W - 1; k >= 0; k--) begin
            if ($urandom_range(0, 39) == 0) send_noise(1);
            if ($urandom_range(0, 29) == 0)
                w = abort_width();
            else if (code[k])
                w = pick_in_window(cfg_now.one_min, cfg_now.one_max);
            else
                w = zero_width();
            send_pulse(w);
        end
    endtask

    task automatic run_traffic(input int budget);
        int start;
        start = edges_sent;
        while (edges_sent - start < budget) begin
            // switch between idling and back-to-back stretches
            if ($urandom_range(0, 7) == 0) begin
                in_gaps_on    = ($urandom_range(0, 2) != 0);
                out_stalls_on = ($urandom_range(0, 2) != 0);
            end
            case ($urandom_range(0, 9))
                0:       send_noise($urandom_range(1, 4));
                1:       send_pulse($urandom_range(0, TS_TOP));
                default: send_frame();
            endcase
        end
    endtask

    task automatic add_row(input logic level, input int unsigned ts, input t_row_kind kind);
        t_script_row row;
        row.level = level;
        row.ts    = ts[TS_W-1:0];
        row.kind  = kind;
        script.push_back(row);
    endtask

    initial begin : stimulus
        t_cfg c;
        // register copy starts from reset values
        cfg_now.leader_min     = LEADER_MIN_RST;
        cfg_now.leader_max     = LEADER_MAX_RST;
        cfg_now.one_min        = ONE_MIN_RST;
        cfg_now.one_max        = ONE_MAX_RST;
        cfg_now.code_left      = CODE_RST;
        cfg_now.code_mid_left  = CODE_RST;
        cfg_now.code_right     = CODE_RST;
        cfg_now.code_mid_right = CODE_RST;

        // directed edges under reset settings
        add_row(1'b0, 0, ROW_QUIET);        // low with no rise pending
        add_row(1'b1, 65534, ROW_QUIET);    // rise at top of time base
        add_row(1'b1, 5, ROW_QUIET);        // repeated high ignored
        add_row(1'b0, 450, ROW_LEADER);     // leader across the wrap
        add_row(1'b1, 500, ROW_QUIET);
        add_row(1'b0, 650, ROW_QUIET);      // one
        add_row(1'b1, 700, ROW_QUIET);
        add_row(1'b0, 750, ROW_QUIET);      // zero, short
        add_row(1'b1, 800, ROW_QUIET);
        add_row(1'b0, 1009, ROW_QUIET);     // one at top of window
        add_row(1'b1, 1100, ROW_QUIET);
        add_row(1'b0, 1200, ROW_QUIET);     // one at bottom of window
        add_row(1'b1, 1300, ROW_QUIET);
        add_row(1'b0, 1399, ROW_QUIET);     // zero just under window
        add_row(1'b1, 1400, ROW_QUIET);
        add_row(1'b0, 1610, ROW_QUIET);     // zero at window end
        add_row(1'b1, 1700, ROW_QUIET);
        add_row(1'b0, 1999, ROW_PREDICT);   // just under abort, frame ends
        add_row(1'b1, 2000, ROW_QUIET);
        add_row(1'b0, 2400, ROW_LEADER);
        add_row(1'b1, 2500, ROW_QUIET);
        add_row(1'b0, 2800, ROW_ABORT);     // abort at the limit
        add_row(1'b1, 65535, ROW_QUIET);    // out-of-range stamp
        add_row(1'b0, 3, ROW_QUIET);        // short idle pulse

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        out_stalls_on = 1'b1;
        foreach (script[i])
            push_edge(script[i].level, script[i].ts, script[i].kind != ROW_PREDICT,
                      fixed_result(script[i].kind));
        now_ts = 3000;
        in_gaps_on = 1'b1;

        // nominal windows, random codes
        c = rand_cfg();
        load_settings(make_cfg(LEADER_MIN_RST, LEADER_MAX_RST, ONE_MIN_RST, ONE_MAX_RST, c));
        run_traffic(400);

        // nearly everything is a leader and a one
        c.code_left      = 7'h7F;
        c.code_mid_left  = 7'h7F;
        c.code_right     = 7'h00;
        c.code_mid_right = 7'h7F;
        load_settings(make_cfg(0, TS_TOP, 0, TS_TOP, c));
        run_traffic(250);

        // all registers at maximum: empty leader window
        c.code_right = 7'h7F;
        load_settings(make_cfg(65535, 65535, 65535, 65535, c));
        run_traffic(60);

        // empty one window: only zeros and aborts
        c.code_left      = 7'h00;
        c.code_mid_left  = 7'h00;
        c.code_right     = 7'h00;
        c.code_mid_right = 7'h00;
        load_settings(make_cfg(LEADER_MIN_RST, LEADER_MAX_RST, ONE_MAX_RST, ONE_MIN_RST, c));
        run_traffic(250);

        // single-tick windows at zero
        c = rand_cfg();
        load_settings(make_cfg(0, 1, 0, 1, c));
        run_traffic(200);

        repeat (3) begin
            load_settings(rand_cfg());
            run_traffic(200);
        end

        drain_results();
        $display("covered %0d edge transfers: %0d frames (%0d matched a slot),",
                 edges_sent, frames_out, slot_hits);
        $display("%0d leaders, %0d aborts over %0d register settings, with empty,",
                 leaders_out, aborts_out, settings_used + 1);
        $display("single-tick and full-range windows");
        if (fail_count == 0 && results_due.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
